@@ design/pmm_pkg.sv @@
`default_nettype none
// Package for the pooled message mailboxes block.
// Holds the transfer item types and the request and status codes; no dependencies.
package pmm_pkg;

    localparam int MODE_BITS   = 2;
    localparam int SENDER_BITS = 4;
    localparam int BOX_BITS    = 4;
    localparam int MSG_BITS    = 32;
    localparam int STATUS_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_ADD_TAIL = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD_HEAD = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_GET_ANY  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_GET_FROM = 2'd3;

    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [SENDER_BITS-1:0] sender_id;
        logic [BOX_BITS-1:0]    dest_thread;
        logic [MSG_BITS-1:0]    msg_word;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [MSG_BITS-1:0]    got_word;
        logic [SENDER_BITS-1:0] got_sender;
    } t_out_item;

endpackage
`default_nettype wire

@@ design/pmm_ram.sv @@
`default_nettype none
// Simple dual-port RAM with one write port and one registered read port.
// Used for the slot tables of the mailbox sequencer; no dependencies.
module pmm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ design/pmm_seq.sv @@
`default_nettype none
// Request sequencer: mailbox head and tail table, free pool pointers and slot RAMs.
// Depends on pmm_pkg and pmm_ram.
module pmm_seq #(
    parameter int MSG_SLOTS = 64,
    parameter int THREADS   = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_req_valid,
    input  wire pmm_pkg::t_in_item  i_req,
    output logic                    o_ready,
    output logic                    o_res_valid,
    input  wire                     i_res_take,
    output pmm_pkg::t_out_item      o_res
);

    localparam int IW    = $clog2(MSG_SLOTS);
    localparam int PW    = $clog2(MSG_SLOTS + 1);
    localparam int BOXES = (THREADS < 16) ? THREADS : 16;
    localparam int BW    = $clog2(BOXES);
    localparam int DW    = pmm_pkg::SENDER_BITS + WORD_BITS;
    localparam logic [PW-1:0] NIL  = PW'(MSG_SLOTS);
    localparam logic [PW-1:0] LAST = PW'(MSG_SLOTS - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADD, S_ALNK, S_AFIN, S_GET, S_CHK, S_DET, S_DNXT, S_DPOOL, S_RESP
    } t_state;

    t_state             r_state;
    logic [PW-1:0]      r_cnt;
    pmm_pkg::t_in_item  r_req;
    logic [IW-1:0]      r_slot;
    logic [PW-1:0]      r_link;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_n;
    logic [PW-1:0]      r_phead;
    logic [PW-1:0]      r_ptail;
    logic [PW-1:0]      r_bhead [BOXES];
    logic [PW-1:0]      r_btail [BOXES];
    pmm_pkg::t_out_item r_res;

    logic          nx_we, pv_we, dt_we;
    logic [IW-1:0] nx_wa, pv_wa, dt_wa, rd_a;
    logic [PW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [DW-1:0] dt_wd, dt_rd;

    logic [BW-1:0]                   bidx;
    logic                            box_ok, add_ok, is_tail, match;
    logic [PW-1:0]                   bh, bt, slot_p;
    logic [WORD_BITS+31:0]           w_in, w_out;
    logic [pmm_pkg::SENDER_BITS-1:0] rd_sender;

    assign bidx      = r_req.dest_thread[BW-1:0];
    assign box_ok    = {5'd0, r_req.dest_thread} < 9'(THREADS);
    assign bh        = r_bhead[bidx];
    assign bt        = r_btail[bidx];
    assign add_ok    = box_ok && (r_phead != NIL);
    assign is_tail   = (r_req.mode == pmm_pkg::MODE_ADD_TAIL);
    assign slot_p    = PW'(r_slot);
    assign w_in      = {{WORD_BITS{1'b0}}, r_req.msg_word};
    assign w_out     = {32'd0, dt_rd[WORD_BITS-1:0]};
    assign rd_sender = dt_rd[DW-1:WORD_BITS];
    assign match     = (r_req.mode == pmm_pkg::MODE_GET_ANY) || (rd_sender == r_req.sender_id);

    always_comb begin
        nx_we = 1'b0;
        nx_wa = r_slot;
        nx_wd = NIL;
        pv_we = 1'b0;
        pv_wa = r_slot;
        pv_wd = NIL;
        dt_we = 1'b0;
        dt_wa = r_phead[IW-1:0];
        dt_wd = {r_req.sender_id, w_in[WORD_BITS-1:0]};
        rd_a  = r_slot;
        unique case (r_state)
            S_INIT: begin
                nx_we = 1'b1;
                nx_wa = r_cnt[IW-1:0];
                nx_wd = PW'(r_cnt + 1'b1);
            end
            S_ADD: begin
                rd_a  = r_phead[IW-1:0];
                dt_we = add_ok;
            end
            S_ALNK: begin
                nx_we = 1'b1;
                nx_wd = is_tail ? NIL : bh;
                pv_we = 1'b1;
                pv_wd = is_tail ? bt : NIL;
            end
            S_AFIN: begin
                nx_we = is_tail && (r_link != NIL);
                nx_wa = r_link[IW-1:0];
                nx_wd = slot_p;
                pv_we = !is_tail && (r_link != NIL);
                pv_wa = r_link[IW-1:0];
                pv_wd = slot_p;
            end
            S_GET: begin
                rd_a = bh[IW-1:0];
            end
            S_CHK: begin
                if (!match) begin
                    rd_a = nx_rd[IW-1:0];
                end
            end
            S_DET: begin
                nx_we = (r_p != NIL);
                nx_wa = r_p[IW-1:0];
                nx_wd = r_n;
                pv_we = (r_n != NIL);
                pv_wa = r_n[IW-1:0];
                pv_wd = r_p;
            end
            S_DNXT: begin
                nx_we = 1'b1;
            end
            S_DPOOL: begin
                nx_we = (r_ptail != NIL);
                nx_wa = r_ptail[IW-1:0];
                nx_wd = slot_p;
            end
            default: begin
            end
        endcase
    end

    pmm_ram #(.DEPTH(MSG_SLOTS), .WIDTH(PW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(rd_a), .o_rdata(nx_rd)
    );

    pmm_ram #(.DEPTH(MSG_SLOTS), .WIDTH(PW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(rd_a), .o_rdata(pv_rd)
    );

    pmm_ram #(.DEPTH(MSG_SLOTS), .WIDTH(DW)) u_data (
        .i_clk(i_clk), .i_we(dt_we), .i_waddr(dt_wa), .i_wdata(dt_wd),
        .i_raddr(rd_a), .o_rdata(dt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_phead <= '0;
            r_ptail <= LAST;
            for (int i = 0; i < BOXES; i++) begin
                r_bhead[i] <= NIL;
                r_btail[i] <= NIL;
            end
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= PW'(r_cnt + 1'b1);
                    if (r_cnt == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= i_req.mode[1] ? S_GET : S_ADD;
                    end
                end
                S_ADD: begin
                    if (!add_ok) begin
                        r_res   <= '{pmm_pkg::STAT_FULL, '0, '0};
                        r_state <= S_RESP;
                    end else begin
                        r_slot  <= r_phead[IW-1:0];
                        r_link  <= is_tail ? bt : bh;
                        r_state <= S_ALNK;
                    end
                end
                S_ALNK: begin
                    r_phead <= nx_rd;
                    if (nx_rd == NIL) begin
                        r_ptail <= NIL;
                    end
                    if (is_tail) begin
                        if (bt == NIL) begin
                            r_bhead[bidx] <= slot_p;
                        end
                        r_btail[bidx] <= slot_p;
                    end else begin
                        if (bh == NIL) begin
                            r_btail[bidx] <= slot_p;
                        end
                        r_bhead[bidx] <= slot_p;
                    end
                    r_state <= S_AFIN;
                end
                S_AFIN: begin
                    r_res   <= '{pmm_pkg::STAT_OK, '0, '0};
                    r_state <= S_RESP;
                end
                S_GET: begin
                    if (!box_ok || bh == NIL) begin
                        r_res   <= '{pmm_pkg::STAT_EMPTY, '0, '0};
                        r_state <= S_RESP;
                    end else begin
                        r_slot  <= bh[IW-1:0];
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (match) begin
                        r_p     <= pv_rd;
                        r_n     <= nx_rd;
                        r_res   <= '{pmm_pkg::STAT_OK, w_out[31:0], rd_sender};
                        r_state <= S_DET;
                    end else if (nx_rd == NIL) begin
                        r_res   <= '{pmm_pkg::STAT_EMPTY, '0, '0};
                        r_state <= S_RESP;
                    end else begin
                        r_slot <= nx_rd[IW-1:0];
                    end
                end
                S_DET: begin
                    if (r_p == NIL) begin
                        r_bhead[bidx] <= r_n;
                    end
                    if (r_n == NIL) begin
                        r_btail[bidx] <= r_p;
                    end
                    r_state <= S_DNXT;
                end
                S_DNXT: begin
                    r_state <= S_DPOOL;
                end
                S_DPOOL: begin
                    if (r_ptail == NIL) begin
                        r_phead <= slot_p;
                    end
                    r_ptail <= slot_p;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

endmodule
`default_nettype wire

@@ design/pooled_message_mailboxes.sv @@
`default_nettype none
// Top level of the pooled message mailboxes block: sequencer and output register.
// Depends on pmm_pkg and pmm_seq.
//
// One request is served at a time. After reset the block links the free pool in the
// next-link RAM before it takes its first transfer. A successful add passes S_ADD,
// S_ALNK and S_AFIN before its result goes to the output register; a successful get
// passes S_GET, S_CHK once per slot visited in the mailbox (the sender search reads
// one slot per cycle from the single read port of the slot RAMs), S_DET, S_DNXT, S_DPOOL.
// A result waiting for the output register keeps the next request from being accepted.
module pooled_message_mailboxes #(
    parameter int MSG_SLOTS = 64,
    parameter int THREADS   = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire pmm_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output pmm_pkg::t_out_item      o_out_data
);

    logic               ready, res_valid, take;
    pmm_pkg::t_out_item res;
    logic               r_ovld;
    pmm_pkg::t_out_item r_odata;

    pmm_seq #(.MSG_SLOTS(MSG_SLOTS), .THREADS(THREADS), .WORD_BITS(WORD_BITS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_in_valid), .i_req(i_in_data),
        .o_ready(ready), .o_res_valid(res_valid), .i_res_take(take), .o_res(res)
    );

    assign take = res_valid && (!r_ovld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (take) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
        if (take) begin
            r_odata <= res;
        end
    end

    assign o_in_stall  = !ready;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

endmodule
`default_nettype wire

@@ bench/pooled_message_mailboxes_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the pooled message mailboxes block.
// Depends on pmm_pkg and the pooled_message_mailboxes top level.

module pooled_message_mailboxes_test;

    localparam int SLOTS = 64;
    localparam int BOXES = 16;
    localparam int NIL   = SLOTS;
    localparam int CYCLE_LIMIT = 600000;

    class mailbox_scoreboard;
        logic [pmm_pkg::SENDER_BITS-1:0] sender_mem [SLOTS];
        logic [pmm_pkg::MSG_BITS-1:0]    word_mem [SLOTS];
        int next_link [SLOTS];
        int prev_link [SLOTS];
        int head [BOXES];
        int tail [BOXES];
        int free_head;
        int free_tail;
        pmm_pkg::t_out_item pending [$];
        int errors;

        function void clear();
            for (int i = 0; i < SLOTS; i++) begin
                next_link[i] = i + 1;
                prev_link[i] = 0;
                sender_mem[i] = '0;
                word_mem[i] = '0;
            end
            for (int b = 0; b < BOXES; b++) begin
                head[b] = NIL;
                tail[b] = NIL;
            end
            free_head = 0;
            free_tail = SLOTS - 1;
            pending.delete();
            errors = 0;
        endfunction

        function void note_request(pmm_pkg::t_in_item req);
            pmm_pkg::t_out_item res;
            int s;
            int box;
            int found;
            int p;
            int n;
            res = '0;
            box = int'(req.dest_thread);
            if (req.mode == pmm_pkg::MODE_ADD_TAIL || req.mode == pmm_pkg::MODE_ADD_HEAD) begin
                s = free_head;
                if (s >= NIL) begin
                    res.status = pmm_pkg::STAT_FULL;
                end else begin
                    free_head = next_link[s];
                    if (free_head >= NIL) free_tail = NIL;
                    sender_mem[s] = req.sender_id;
                    word_mem[s] = req.msg_word;
                    if (req.mode == pmm_pkg::MODE_ADD_TAIL) begin
                        prev_link[s] = tail[box];
                        next_link[s] = NIL;
                        if (tail[box] >= NIL) head[box] = s;
                        else next_link[tail[box]] = s;
                        tail[box] = s;
                    end else begin
                        prev_link[s] = NIL;
                        next_link[s] = head[box];
                        if (head[box] >= NIL) tail[box] = s;
                        else prev_link[head[box]] = s;
                        head[box] = s;
                    end
                    res.status = pmm_pkg::STAT_OK;
                end
            end else begin
                found = NIL;
                s = head[box];
                while (s < NIL) begin
                    if (req.mode == pmm_pkg::MODE_GET_ANY || sender_mem[s] == req.sender_id) begin
                        found = s;
                        break;
                    end
                    s = next_link[s];
                end
                if (found >= NIL) begin
                    res.status = pmm_pkg::STAT_EMPTY;
                end else begin
                    res.status = pmm_pkg::STAT_OK;
                    res.got_word = word_mem[found];
                    res.got_sender = sender_mem[found];
                    p = prev_link[found];
                    n = next_link[found];
                    if (p >= NIL) head[box] = n; else next_link[p] = n;
                    if (n >= NIL) tail[box] = p; else prev_link[n] = p;
                    next_link[found] = NIL;
                    if (free_tail >= NIL) free_head = found;
                    else next_link[free_tail] = found;
                    free_tail = found;
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(pmm_pkg::t_out_item got);
            pmm_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.got_word !== want.got_word) begin
                $display("%0t got_word expected %h actual %h", $time, want.got_word,
                    got.got_word);
                errors++;
            end
            if (got.got_sender !== want.got_sender) begin
                $display("%0t got_sender expected %0d actual %0d", $time, want.got_sender,
                    got.got_sender);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    pmm_pkg::t_in_item i_in_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    pmm_pkg::t_out_item o_out_data;
    int cycle_count = 0;
    bit stall_free = 1'b0;
    mailbox_scoreboard board;

    pooled_message_mailboxes uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
        if (stall_free) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < ((cycle_count / 3000) % 3) * 30);
    end

    task automatic send_request(pmm_pkg::t_in_item req);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
    endtask

    task automatic pause_sender(int cycles);
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic pmm_pkg::t_in_item make_request(logic [1:0] mode, int snd, int box,
                                                       logic [31:0] word);
        pmm_pkg::t_in_item r;
        r.mode = mode;
        r.sender_id = 4'(snd);
        r.dest_thread = 4'(box);
        r.msg_word = word;
        return r;
    endfunction

    function automatic pmm_pkg::t_in_item random_request();
        int box;
        int roll;
        logic [1:0] mode;
        box = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        roll = $urandom_range(0, 99);
        if (board.free_head >= NIL && roll < 50) roll = 60;
        if (roll < 25) mode = pmm_pkg::MODE_ADD_TAIL;
        else if (roll < 45) mode = pmm_pkg::MODE_ADD_HEAD;
        else if (roll < 70) mode = pmm_pkg::MODE_GET_ANY;
        else mode = pmm_pkg::MODE_GET_FROM;
        return make_request(mode, $urandom_range(0, 15) & ($urandom_range(0, 1) ? 15 : 3),
            box, $urandom());
    endfunction

    initial begin
        int burst;
        board = new();
        board.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_request(pmm_pkg::MODE_GET_ANY, 0, 0, 32'h0));
        send_request(make_request(pmm_pkg::MODE_GET_FROM, 5, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_ADD_TAIL, 15, 15, 32'hFFFF_FFFF));
        send_request(make_request(pmm_pkg::MODE_ADD_HEAD, 0, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_ADD_TAIL, 9, 15, 32'hA5A5_5A5A));
        send_request(make_request(pmm_pkg::MODE_GET_FROM, 3, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_GET_FROM, 9, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_GET_ANY, 0, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_GET_FROM, 15, 15, 32'h0));
        send_request(make_request(pmm_pkg::MODE_GET_ANY, 0, 15, 32'h0));
        for (int i = 0; i < SLOTS; i++)
            send_request(make_request(pmm_pkg::MODE_ADD_TAIL, i % 16, i % 2, $urandom()));
        send_request(make_request(pmm_pkg::MODE_ADD_HEAD, 1, 3, 32'h1234_5678));
        send_request(make_request(pmm_pkg::MODE_ADD_TAIL, 1, 3, 32'h1234_5678));
        send_request(make_request(pmm_pkg::MODE_GET_FROM, 15, 1, 32'h0));
        for (int i = 0; i < SLOTS; i++)
            send_request(make_request(pmm_pkg::MODE_GET_ANY, 0, i % 2, 32'h0));

        for (int n = 0; n < 1800; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                send_request(random_request());
                n++;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
        pause_sender(0);
        stall_free = 1'b1;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
